/* rtl/dte_pkg.sv */
package dte_pkg;

    localparam int EPOCH_W   = 38;
    localparam int MAC_A_W   = 22;
    localparam int MAC_B_W   = 17;
    localparam int YEAR_W    = 14;
    localparam int DAYS_W    = 22;
    localparam int Q_W       = 7;

    localparam int Q100_SH   = 19;
    localparam logic [MAC_B_W-1:0] Q100_MUL  = 17'd5243;
    localparam logic [MAC_B_W-1:0] DAY_DAYS  = 17'd365;
    localparam logic [MAC_B_W-1:0] DAY_SECS  = 17'd86400;
    localparam logic [MAC_B_W-1:0] HOUR_SECS = 17'd3600;
    localparam logic [MAC_B_W-1:0] MIN_SECS  = 17'd60;
    localparam logic [MAC_B_W-1:0] ONE       = 17'd1;

    localparam logic [31:0] HI_MIN = 32'd70;
    localparam logic [31:0] HI_MAX = 32'd8099;
    localparam logic [YEAR_W-1:0] YEAR_BASE   = 14'd1900;
    localparam logic [YEAR_W-1:0] YEAR_EPOCH  = 14'd1970;
    localparam logic [YEAR_W-1:0] LEAPS_EPOCH = 14'd477;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MQ1,
        S_MQ4,
        S_MQY,
        S_CHK,
        S_MDAY1,
        S_MDAY2,
        S_MHR,
        S_MMIN,
        S_MSEC,
        S_DONE
    } t_state;

    function automatic logic [4:0] f_mlen(input logic [3:0] idx);
        logic [4:0] len;
        unique case (idx)
            4'd1:                      len = 5'd28;
            4'd3, 4'd5, 4'd8, 4'd10:   len = 5'd30;
            default:                   len = 5'd31;
        endcase
        return len;
    endfunction

    function automatic logic [8:0] f_mstart(input logic [3:0] idx);
        logic [8:0] st;
        unique case (idx)
            4'd0:    st = 9'd0;
            4'd1:    st = 9'd31;
            4'd2:    st = 9'd59;
            4'd3:    st = 9'd90;
            4'd4:    st = 9'd120;
            4'd5:    st = 9'd151;
            4'd6:    st = 9'd181;
            4'd7:    st = 9'd212;
            4'd8:    st = 9'd243;
            4'd9:    st = 9'd273;
            4'd10:   st = 9'd304;
            4'd11:   st = 9'd334;
            default: st = 9'd0;
        endcase
        return st;
    endfunction

endpackage

/* rtl/dte_mac.sv */
module dte_mac (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic [dte_pkg::MAC_A_W-1:0]  i_a,
    input  logic [dte_pkg::MAC_B_W-1:0]  i_b,
    input  logic [dte_pkg::EPOCH_W-1:0]  i_c,
    output logic [dte_pkg::EPOCH_W-1:0]  o_res
);
    import dte_pkg::*;

    logic [MAC_A_W+MAC_B_W-1:0] w_prod;
    logic [EPOCH_W-1:0]         r_res;
    logic [EPOCH_W-1:0]         n_res;

    assign w_prod = i_a * i_b;
    assign n_res  = w_prod[EPOCH_W-1:0] + i_c;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res <= n_res;
        end
    end

    assign o_res = r_res;

endmodule

/* rtl/toy_datetime_to_epoch.sv */
// channel   direction  handshake            payload
// in        input      i_valid / o_stall    i_toy_high_word, i_toy_low_word
// out       output     o_valid / i_stall    o_date_valid, o_epoch_seconds
//
// A valid date loads its result after eight passes through one shared multiply-add unit
// (year quotients, day count, seconds) and one range check.
// A date failing the range check loads its result after the quotient passes and the check.
// o_stall is high while busy, through the load; the next beat is accepted in the cycle after.
// A result held by i_stall delays the load of the next one, not its acceptance.
// Reset is synchronous, active low, and clears the sequencer and o_valid.
module toy_datetime_to_epoch (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [31:0]                  i_toy_high_word,
    input  logic [31:0]                  i_toy_low_word,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic                         o_date_valid,
    output logic [dte_pkg::EPOCH_W-1:0]  o_epoch_seconds
);
    import dte_pkg::*;

    t_state r_state;
    t_state n_state;

    logic [YEAR_W-1:0]  r_year;
    logic [3:0]         r_month;
    logic [4:0]         r_day;
    logic [4:0]         r_hour;
    logic [5:0]         r_min;
    logic [5:0]         r_sec;
    logic               r_ok;
    logic               r_good;
    logic               r_leap;
    logic [Q_W-1:0]     r_q1;
    logic [Q_W-1:0]     r_q4;
    logic [DAYS_W-1:0]  r_days;
    logic               r_o_valid;
    logic               r_o_date_valid;
    logic [EPOCH_W-1:0] r_o_epoch;

    logic               w_accept;
    logic               w_load;
    logic               w_mac_en;
    logic [MAC_A_W-1:0] w_a;
    logic [MAC_B_W-1:0] w_b;
    logic [EPOCH_W-1:0] w_c;
    logic [EPOCH_W-1:0] w_res;
    logic [YEAR_W-1:0]  w_ym1;
    logic [YEAR_W-1:0]  w_leap_sum;
    logic [YEAR_W-1:0]  w_yoff;
    logic [3:0]         w_midx;
    logic [8:0]         w_doy;
    logic [Q_W-1:0]     w_q;
    logic               w_leap;
    logic [4:0]         w_mlen;
    logic               w_in_ok;
    logic [5:0]         w_fmonth;
    logic [4:0]         w_fday;
    logic [4:0]         w_fhour;
    logic [5:0]         w_fmin;
    logic [5:0]         w_fsec;

    assign w_fmonth = i_toy_low_word[31:26];
    assign w_fday   = i_toy_low_word[25:21];
    assign w_fhour  = i_toy_low_word[20:16];
    assign w_fmin   = i_toy_low_word[15:10];
    assign w_fsec   = i_toy_low_word[9:4];

    assign w_in_ok = (i_toy_high_word >= HI_MIN) && (i_toy_high_word <= HI_MAX)
                  && (w_fmonth != 6'd0) && (w_fmonth <= 6'd12) && (w_fday != 5'd0)
                  && (w_fhour <= 5'd23) && (w_fmin <= 6'd59) && (w_fsec <= 6'd59);

    assign w_accept = i_valid && !o_stall;
    assign w_load   = (r_state == S_DONE) && (!r_o_valid || !i_stall);
    assign o_stall  = (r_state != S_IDLE);

    assign w_ym1      = r_year - 14'd1;
    assign w_yoff     = r_year - YEAR_EPOCH;
    assign w_leap_sum = {2'b00, w_ym1[YEAR_W-1:2]} + {7'd0, r_q4} - {7'd0, r_q1}
                      - LEAPS_EPOCH;
    assign w_midx     = r_month - 4'd1;
    assign w_doy      = f_mstart(w_midx) + {8'd0, (r_leap && (r_month > 4'd2))}
                      + {4'd0, r_day} - 9'd1;
    assign w_q        = w_res[Q100_SH+Q_W-1:Q100_SH];
    assign w_leap     = (r_year[1:0] == 2'b00) && ((w_q == r_q1) || (w_q[1:0] == 2'b00));
    assign w_mlen     = f_mlen(w_midx) + {4'd0, (w_leap && (r_month == 4'd2))};

    always_comb begin
        n_state  = r_state;
        w_mac_en = 1'b1;
        w_a      = '0;
        w_b      = ONE;
        w_c      = '0;
        unique case (r_state)
            S_IDLE: begin
                w_mac_en = 1'b0;
                if (w_accept) n_state = S_MQ1;
            end
            S_MQ1: begin
                w_a     = {8'd0, w_ym1};
                w_b     = Q100_MUL;
                n_state = S_MQ4;
            end
            S_MQ4: begin
                w_a     = {10'd0, w_ym1[YEAR_W-1:2]};
                w_b     = Q100_MUL;
                n_state = S_MQY;
            end
            S_MQY: begin
                w_a     = {8'd0, r_year};
                w_b     = Q100_MUL;
                n_state = S_CHK;
            end
            S_CHK: begin
                w_mac_en = 1'b0;
                n_state  = (r_ok && (r_day <= w_mlen)) ? S_MDAY1 : S_DONE;
            end
            S_MDAY1: begin
                w_a     = {8'd0, w_yoff};
                w_b     = DAY_DAYS;
                w_c     = {24'd0, w_leap_sum};
                n_state = S_MDAY2;
            end
            S_MDAY2: begin
                w_a     = {13'd0, w_doy};
                w_b     = ONE;
                w_c     = w_res;
                n_state = S_MHR;
            end
            S_MHR: begin
                w_a     = {17'd0, r_hour};
                w_b     = HOUR_SECS;
                w_c     = {32'd0, r_sec};
                n_state = S_MMIN;
            end
            S_MMIN: begin
                w_a     = {16'd0, r_min};
                w_b     = MIN_SECS;
                w_c     = w_res;
                n_state = S_MSEC;
            end
            S_MSEC: begin
                w_a     = r_days;
                w_b     = DAY_SECS;
                w_c     = w_res;
                n_state = S_DONE;
            end
            S_DONE: begin
                w_mac_en = 1'b0;
                if (w_load) n_state = S_IDLE;
            end
            default: begin
                w_mac_en = 1'b0;
                n_state  = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_year  <= YEAR_BASE + i_toy_high_word[YEAR_W-1:0];
            r_month <= w_fmonth[3:0];
            r_day   <= w_fday;
            r_hour  <= w_fhour;
            r_min   <= w_fmin;
            r_sec   <= w_fsec;
            r_ok    <= w_in_ok;
        end
        if (r_state == S_MQ4) r_q1 <= w_q;
        if (r_state == S_MQY) r_q4 <= w_q;
        if (r_state == S_CHK) r_leap <= w_leap;
        if (r_state == S_MHR) r_days <= w_res[DAYS_W-1:0];
        if (r_state == S_IDLE) r_good <= 1'b0;
        if (r_state == S_MSEC) r_good <= 1'b1;
        if (w_load) begin
            r_o_date_valid <= r_good;
            r_o_epoch      <= r_good ? w_res : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_load) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    dte_mac u_mac (
        .i_clk (i_clk),
        .i_en  (w_mac_en),
        .i_a   (w_a),
        .i_b   (w_b),
        .i_c   (w_c),
        .o_res (w_res)
    );

    assign o_valid         = r_o_valid;
    assign o_date_valid    = r_o_date_valid;
    assign o_epoch_seconds = r_o_epoch;

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> o_valid)
        else $error("result load did not raise o_valid");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_date_valid) |-> (o_epoch_seconds == '0))
        else $error("invalid date with nonzero epoch");

    a_epoch_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_date_valid) |-> (o_epoch_seconds < 38'd253402300800))
        else $error("epoch beyond year 9999");

    a_accept_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_MQ1))
        else $error("accepted beat did not start the sequence");

endmodule
